[src/twdbm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twdbm_pkg
// Shared command codes, segment counts and the result record of the
// two-wire display bus master.
// ----------------------------------------------------------------------------
package twdbm_pkg;

    localparam int unsigned CMD_W  = 3;
    localparam int unsigned SEG_W  = 5;
    localparam int unsigned BYTE_W = 8;

    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_IDLE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;

    localparam logic [SEG_W-1:0] SEG_CNT_WRITE = 5'd20;
    localparam logic [SEG_W-1:0] SEG_CNT_READ  = 5'd18;
    localparam logic [SEG_W-1:0] SEG_CNT_SHORT = 5'd2;

    // bit positions inside the output tdata
    localparam int unsigned OB_CLK  = 0;
    localparam int unsigned OB_DIO  = 1;
    localparam int unsigned OB_BUSY = 2;
    localparam int unsigned OB_DONE = 3;
    localparam int unsigned OB_RD   = 4;
    localparam int unsigned OB_ACK  = 12;
    localparam int unsigned OB_IGN  = 13;

    typedef struct packed {
        logic              clk_drive_low;
        logic              dio_drive_low;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rd_byte;
        logic              ack_level;
        logic              cmd_ignored;
    } t_result;

endpackage
`default_nettype wire

[src/twdbm_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twdbm_core
// Bus state (command, segment, shift register, pin latches) and the
// combinational segment sequencing logic for one beat.
// ----------------------------------------------------------------------------
module twdbm_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic [twdbm_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic [twdbm_pkg::BYTE_W-1:0]  i_wr_byte,
    input  wire logic                          i_dio_in,
    output twdbm_pkg::t_result                 o_res
);

    logic [twdbm_pkg::CMD_W-1:0]  r_act,  n_act;
    logic [twdbm_pkg::SEG_W-1:0]  r_seg,  n_seg;
    logic [twdbm_pkg::BYTE_W-1:0] r_sh,   n_sh;
    logic                         r_clk,  n_clk;
    logic                         r_dmode, n_dmode;
    logic                         r_dlat, n_dlat;
    logic                         r_ack,  n_ack;

    logic                         do_enter;
    logic [twdbm_pkg::SEG_W-1:0]  k;
    logic [twdbm_pkg::CMD_W-1:0]  c;
    logic [twdbm_pkg::SEG_W-1:0]  seg_inc;
    logic [twdbm_pkg::SEG_W-1:0]  seg_total;
    logic                         done;
    logic                         ign;
    logic [twdbm_pkg::BYTE_W-1:0] rd;

    assign seg_inc = r_seg + 1'b1;

    always_comb begin
        unique case (r_act)
            twdbm_pkg::CMD_WRITE: seg_total = twdbm_pkg::SEG_CNT_WRITE;
            twdbm_pkg::CMD_READ:  seg_total = twdbm_pkg::SEG_CNT_READ;
            default:              seg_total = twdbm_pkg::SEG_CNT_SHORT;
        endcase
    end

    always_comb begin
        n_act    = r_act;
        n_seg    = r_seg;
        n_sh     = r_sh;
        n_clk    = r_clk;
        n_dmode  = r_dmode;
        n_dlat   = r_dlat;
        n_ack    = r_ack;
        do_enter = 1'b0;
        k        = '0;
        c        = r_act;
        done     = 1'b0;
        ign      = 1'b0;
        rd       = '0;

        if (i_en) begin
            if (i_cmd == twdbm_pkg::CMD_TICK) begin
                if (r_act != twdbm_pkg::CMD_IDLE) begin
                    // close current segment: sample data line
                    if (r_act == twdbm_pkg::CMD_WRITE) begin
                        if (r_seg == 5'd19) n_ack = i_dio_in;
                    end else if (r_act == twdbm_pkg::CMD_READ) begin
                        if (r_seg < 5'd16 && !r_seg[0]) begin
                            n_sh = {r_sh[twdbm_pkg::BYTE_W-2:0], i_dio_in};
                        end else if (r_seg == 5'd17) begin
                            n_ack = i_dio_in;
                        end
                    end
                    if (seg_inc != seg_total) begin
                        n_seg    = seg_inc;
                        do_enter = 1'b1;
                        k        = seg_inc;
                    end else begin
                        if (r_act == twdbm_pkg::CMD_WRITE || r_act == twdbm_pkg::CMD_READ) begin
                            n_dmode = 1'b1;
                        end
                        if (r_act == twdbm_pkg::CMD_READ) rd = n_sh;
                        done  = 1'b1;
                        n_act = twdbm_pkg::CMD_IDLE;
                        n_seg = '0;
                    end
                end
            end else if (i_cmd <= twdbm_pkg::CMD_STOP) begin
                if (r_act != twdbm_pkg::CMD_IDLE) begin
                    ign = 1'b1;
                end else begin
                    n_act    = i_cmd;
                    n_seg    = '0;
                    c        = i_cmd;
                    do_enter = 1'b1;
                    if (i_cmd == twdbm_pkg::CMD_WRITE) n_sh = i_wr_byte;
                    else if (i_cmd == twdbm_pkg::CMD_READ) n_sh = '0;
                end
            end
        end

        // pin changes as segment k opens
        if (do_enter) begin
            unique case (c)
                twdbm_pkg::CMD_START: begin
                    n_dmode = (k != '0);
                    n_clk   = (k != '0);
                end
                twdbm_pkg::CMD_STOP: begin
                    n_dmode = (k == '0);
                    n_clk   = (k == '0);
                end
                twdbm_pkg::CMD_WRITE: begin
                    if (k < 5'd16) begin
                        if (!k[0]) begin
                            n_clk = 1'b1;
                        end else begin
                            n_dlat = n_sh[twdbm_pkg::BYTE_W-1];
                            n_sh   = {n_sh[twdbm_pkg::BYTE_W-2:0], 1'b0};
                            n_clk  = 1'b0;
                        end
                    end else if (k == 5'd18) begin
                        n_clk   = 1'b1;
                        n_dmode = 1'b0;
                    end else if (k == 5'd19) begin
                        n_clk = 1'b0;
                    end
                end
                twdbm_pkg::CMD_READ: begin
                    if (k == '0) begin
                        n_dmode = 1'b0;
                        n_clk   = 1'b0;
                    end else if (k < 5'd16) begin
                        n_clk = k[0];
                    end else if (k == 5'd16) begin
                        n_clk   = 1'b1;
                        n_dmode = 1'b0;
                    end else begin
                        n_clk = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= twdbm_pkg::CMD_IDLE;
            r_seg   <= '0;
            r_sh    <= '0;
            r_clk   <= 1'b0;
            r_dmode <= 1'b0;
            r_dlat  <= 1'b0;
            r_ack   <= 1'b1;
        end else if (i_en) begin
            r_act   <= n_act;
            r_seg   <= n_seg;
            r_sh    <= n_sh;
            r_clk   <= n_clk;
            r_dmode <= n_dmode;
            r_dlat  <= n_dlat;
            r_ack   <= n_ack;
        end
    end

    always_comb begin
        o_res.clk_drive_low = n_clk;
        o_res.dio_drive_low = n_dmode & ~n_dlat;
        o_res.busy          = (n_act != twdbm_pkg::CMD_IDLE);
        o_res.done          = done;
        o_res.rd_byte       = rd;
        o_res.ack_level     = n_ack;
        o_res.cmd_ignored   = ign;
    end

endmodule
`default_nettype wire

[src/two_wire_display_bus_master_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_wire_display_bus_master_top
// Bit-level master for an open-drain two-wire display bus: start, write byte,
// read byte and stop commands, paced by tick beats of one half-bit each.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A beat is taken every cycle while the output is
// not stalled; each accepted beat passes through the input register, then
// through the segment sequencer into the result register. Back-pressure on
// the output stalls the input register, which in turn drops s_tready.
module two_wire_display_bus_master_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [7:0] wr_byte, [8] dio_in, [15:9] zero
    input  wire logic [7:0]  i_s_tuser,   // [2:0] cmd, [7:3] zero
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata    // [0] clk_drive_low, [1] dio_drive_low,
                                          // [2] busy_res, [3] done_res,
                                          // [11:4] rd_byte, [12] ack_level,
                                          // [13] cmd_ignored, [15:14] zero
);

    logic                          r_in_valid;
    logic [twdbm_pkg::CMD_W-1:0]   r_cmd;
    logic [twdbm_pkg::BYTE_W-1:0]  r_wr_byte;
    logic                          r_dio_in;
    logic                          r_out_valid;
    twdbm_pkg::t_result            r_out;
    twdbm_pkg::t_result            res;
    logic                          adv;
    logic                          s_acc;

    assign adv        = r_in_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready = ~r_in_valid | adv;
    assign s_acc      = i_s_tvalid & o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_cmd     <= i_s_tuser[twdbm_pkg::CMD_W-1:0];
            r_wr_byte <= i_s_tdata[7:0];
            r_dio_in  <= i_s_tdata[8];
        end
    end

    twdbm_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_cmd     (r_cmd),
        .i_wr_byte (r_wr_byte),
        .i_dio_in  (r_dio_in),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out.cmd_ignored, r_out.ack_level, r_out.rd_byte,
                         r_out.done, r_out.busy, r_out.dio_drive_low,
                         r_out.clk_drive_low};

endmodule
`default_nettype wire

[src/twdbm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twdbm_checker
// Port-level checks on result beats of the two-wire display bus master.
// ----------------------------------------------------------------------------
module twdbm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] o_m_tdata
);

    // a finished command leaves the bus idle
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[twdbm_pkg::OB_DONE] |-> !o_m_tdata[twdbm_pkg::OB_BUSY])
        else $error("done with busy set");

    // a dropped command implies one still in flight
    a_ign_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[twdbm_pkg::OB_IGN] |->
            o_m_tdata[twdbm_pkg::OB_BUSY] && !o_m_tdata[twdbm_pkg::OB_DONE])
        else $error("ignored command while idle or done");

    // received byte only shows on done
    a_rd_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[twdbm_pkg::OB_RD +: twdbm_pkg::BYTE_W] != 8'd0) |->
            o_m_tdata[twdbm_pkg::OB_DONE])
        else $error("rd_byte nonzero without done");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output beat changed");

endmodule

bind two_wire_display_bus_master_top twdbm_checker u_twdbm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire
